@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define V3AU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vector unit assertion failed");

// Same check with a message of the caller
`define V3AU_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

@@ rtl/core/v3au_pkg.sv @@
`timescale 1ns / 1ps
// Package: types, widths, latencies and step functions of the vector arithmetic unit
package v3au_pkg;

  // Number format and datapath widths
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned QX_W      = Q_W + 1;
  localparam int unsigned PROD_W    = 2 * Q_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned NUM_W     = Q_W + FRAC_BITS;
  localparam int unsigned DIV_STG   = (NUM_W + 1) / 2;
  localparam int unsigned DIV_W     = 2 * DIV_STG;
  localparam int unsigned SQ_STG    = Q_W / 2;
  localparam int unsigned RAD_W     = PROD_W;
  localparam int unsigned SQ_REM_W  = Q_W + 2;
  localparam int unsigned SQ_T_W    = SQ_REM_W + 2;

  // Pipeline depths: divider starts after stage one, root after stage two
  localparam int unsigned LAT_DIV   = DIV_STG + 1;
  localparam int unsigned LAT_SQ    = SQ_STG + 2;
  localparam int unsigned LAT_UNIT  = (LAT_DIV > LAT_SQ) ? LAT_DIV : LAT_SQ;
  localparam int unsigned DIV_PIPE  = LAT_UNIT - 1;
  localparam int unsigned SQ_PIPE   = LAT_UNIT - 2;
  localparam int unsigned CTX_PIPE  = LAT_UNIT - 2;
  localparam int unsigned LATENCY   = LAT_UNIT + 1;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic signed [SUM_W-1:0] S_MAX = {{(SUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] S_MIN = {{(SUM_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RND_HALF =
    {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  localparam logic [DIV_W-1:0] QU_POS_LIM = {{(DIV_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic [DIV_W-1:0] QU_NEG_LIM = {{(DIV_W-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_MAG   = 3'd4,
    OP_DOT   = 3'd5,
    OP_CROSS = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]            op;
    logic signed [Q_W-1:0] a_x;
    logic signed [Q_W-1:0] a_y;
    logic signed [Q_W-1:0] a_z;
    logic signed [Q_W-1:0] b_x;
    logic signed [Q_W-1:0] b_y;
    logic signed [Q_W-1:0] b_z;
    logic signed [Q_W-1:0] scale_factor;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] res_x;
    logic signed [Q_W-1:0] res_y;
    logic signed [Q_W-1:0] res_z;
    logic signed [Q_W-1:0] res_scalar;
    logic                  div_zero;
    logic                  overflow;
  } out_t;

  // Control that leaves the front stage
  typedef struct packed {
    logic       valid;
    logic [2:0] op;
    logic       dz;
    logic [2:0] neg;
    logic [2:0] as_ov;
  } f_ctl_t;

  // Per-beat context that rides along the long units
  typedef struct packed {
    logic                  valid;
    logic [2:0]            op;
    logic                  dz;
    logic [2:0]            neg;
    logic signed [Q_W-1:0] vec_x;
    logic signed [Q_W-1:0] vec_y;
    logic signed [Q_W-1:0] vec_z;
    logic signed [Q_W-1:0] scalar;
    logic                  ov;
  } ctx_t;

  typedef struct packed {
    logic signed [Q_W-1:0] val;
    logic                  ov;
  } sat_t;

  typedef struct packed {
    logic [Q_W-1:0]   rem;
    logic [DIV_W-1:0] quo;
  } div_st_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [Q_W-1:0]      root;
    logic [RAD_W-1:0]    rad;
  } sq_st_t;

  // Round to nearest (ties up), drop the fraction, clamp to the Q range
  function automatic sat_t round_sat(input logic signed [SUM_W-1:0] v);
    sat_t                  r;
    logic signed [SUM_W-1:0] t;
    t = (v + RND_HALF) >>> FRAC_BITS;
    if (t > S_MAX) begin
      r.val = Q_MAX;
      r.ov  = 1'b1;
    end else if (t < S_MIN) begin
      r.val = Q_MIN;
      r.ov  = 1'b1;
    end else begin
      r.val = t[Q_W-1:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

  // Apply the sign to a quotient magnitude and clamp
  function automatic sat_t div_sat(input logic [DIV_W-1:0] q, input logic neg);
    sat_t r;
    r.ov = 1'b0;
    if (!neg) begin
      if (q > QU_POS_LIM) begin
        r.val = Q_MAX;
        r.ov  = 1'b1;
      end else begin
        r.val = q[Q_W-1:0];
      end
    end else begin
      if (q > QU_NEG_LIM) begin
        r.val = Q_MIN;
        r.ov  = 1'b1;
      end else begin
        r.val = ~q[Q_W-1:0] + 1'b1;
      end
    end
    return r;
  endfunction

  // Two restoring division steps
  function automatic div_st_t div_step2(input div_st_t st, input logic [Q_W-1:0] den);
    div_st_t     r;
    logic [Q_W:0] t;
    r = st;
    for (int j = 0; j < 2; j++) begin
      t     = {r.rem, r.quo[DIV_W-1]};
      r.quo = {r.quo[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t        = t - {1'b0, den};
        r.quo[0] = 1'b1;
      end
      r.rem = t[Q_W-1:0];
    end
    return r;
  endfunction

  // Two digit-by-digit square root steps
  function automatic sq_st_t sq_step2(input sq_st_t st);
    sq_st_t            r;
    logic [SQ_T_W-1:0] t;
    logic [SQ_T_W-1:0] trial;
    r = st;
    for (int j = 0; j < 2; j++) begin
      t     = {r.rem, r.rad[RAD_W-1 -: 2]};
      trial = {2'b00, r.root, 2'b01};
      r.rad = {r.rad[RAD_W-3:0], 2'b00};
      if (t >= trial) begin
        t      = t - trial;
        r.root = {r.root[Q_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[Q_W-2:0], 1'b0};
      end
      r.rem = t[SQ_REM_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/vector3_arith_unit.sv @@
`timescale 1ns / 1ps
// Top level: pipelined three-component fixed-point vector arithmetic unit
//
//   channel   handshake        payload    direction
//   command   start / busy     item_i     in   (beat taken when start && !busy)
//   result    done_o strobe    result_o   out  (one cycle, no back-pressure)
//
// Depth is LATENCY in v3au_pkg: the longer of the divider path and the root path, plus the output register;
// the divider at two quotient bits per stage sets it.
// One beat enters every cycle; busy is high only while reset is held.
// Reset clears the valid bits of every stage and the whole context pipe; other data registers are not reset.
// Results leave in the order the beats came in.
module vector3_arith_unit import v3au_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o
);

  f_ctl_t                   f_ctl;
  logic signed [PROD_W-1:0] prod  [6];
  logic signed [Q_W-1:0]    as_v  [3];
  logic [DIV_W-1:0]         num   [3];
  logic [Q_W-1:0]           den;
  logic [DIV_W-1:0]         quo   [3];
  logic [Q_W-1:0]           root;

  f_ctl_t                   s2_ctl_q;
  logic signed [Q_W-1:0]    s2_as_q [3];
  logic signed [SUM_W-1:0]  sum_d   [3];
  logic signed [SUM_W-1:0]  sum_q   [3];
  logic signed [SUM_W-1:0]  dot_d;
  logic signed [SUM_W-1:0]  dot_q;

  sat_t                     rv [3];
  sat_t                     rs;
  ctx_t                     ctx_d;
  ctx_t                     ctx_q [CTX_PIPE];
  ctx_t                     c;
  sat_t                     dq [3];

  logic                     done_d;
  logic                     done_q;
  out_t                     res_d;
  out_t                     res_q;

  assign busy = ~rst_ni;

  v3au_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (item_i),
    .ctl_o   (f_ctl),
    .prod_o  (prod),
    .as_o    (as_v),
    .num_o   (num),
    .den_o   (den)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3au_div_pipe u_div (
      .clk_i (clk_i),
      .num_i (num[i]),
      .den_i (den),
      .quo_o (quo[i])
    );
  end

  // Stage two: product sums, kept exact
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (f_ctl.op == OP_CROSS) begin
        sum_d[i] = SUM_W'(prod[i]) - SUM_W'(prod[i+3]);
      end else begin
        sum_d[i] = SUM_W'(prod[i]);
      end
    end
    dot_d = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      s2_ctl_q <= f_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_as_q <= as_v;
    sum_q   <= sum_d;
    dot_q   <= dot_d;
  end

  // Sum of squares is never negative and fits the radicand
  v3au_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (dot_q[RAD_W-1:0]),
    .root_o (root)
  );

  // Stage three: round and clamp the short operations
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv[i] = round_sat(sum_q[i]);
    end
    rs = round_sat(dot_q);

    ctx_d       = '0;
    ctx_d.valid = s2_ctl_q.valid;
    ctx_d.op    = s2_ctl_q.op;
    ctx_d.dz    = s2_ctl_q.dz;
    ctx_d.neg   = s2_ctl_q.neg;
    case (s2_ctl_q.op)
      OP_ADD, OP_SUB: begin
        ctx_d.vec_x = s2_as_q[0];
        ctx_d.vec_y = s2_as_q[1];
        ctx_d.vec_z = s2_as_q[2];
        ctx_d.ov    = |s2_ctl_q.as_ov;
      end
      OP_SCALE, OP_CROSS: begin
        ctx_d.vec_x = rv[0].val;
        ctx_d.vec_y = rv[1].val;
        ctx_d.vec_z = rv[2].val;
        ctx_d.ov    = rv[0].ov | rv[1].ov | rv[2].ov;
      end
      OP_DOT: begin
        ctx_d.scalar = rs.val;
        ctx_d.ov     = rs.ov;
      end
      default: begin
      end
    endcase
  end

  // Hold the context alongside the divider and root pipes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CTX_PIPE; k++) begin
        ctx_q[k] <= '0;
      end
    end else begin
      ctx_q[0] <= ctx_d;
      for (int k = 1; k < CTX_PIPE; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  // Merge the long-unit results into the output beat
  always_comb begin
    c = ctx_q[CTX_PIPE-1];
    for (int i = 0; i < 3; i++) begin
      dq[i] = div_sat(quo[i], c.neg[i]);
    end
    res_d.res_x      = c.vec_x;
    res_d.res_y      = c.vec_y;
    res_d.res_z      = c.vec_z;
    res_d.res_scalar = c.scalar;
    res_d.div_zero   = 1'b0;
    res_d.overflow   = c.ov;
    case (c.op)
      OP_DIV: begin
        if (c.dz) begin
          res_d.res_x    = '0;
          res_d.res_y    = '0;
          res_d.res_z    = '0;
          res_d.div_zero = 1'b1;
          res_d.overflow = 1'b0;
        end else begin
          res_d.res_x    = dq[0].val;
          res_d.res_y    = dq[1].val;
          res_d.res_z    = dq[2].val;
          res_d.overflow = dq[0].ov | dq[1].ov | dq[2].ov;
        end
      end
      OP_MAG: begin
        res_d.res_scalar = root[Q_W-1] ? Q_MAX : root;
        res_d.overflow   = root[Q_W-1];
      end
      default: begin
      end
    endcase
    done_d = c.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/core/v3au_div_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: one lane, two quotient bits per stage
module v3au_div_pipe import v3au_pkg::*; (
  input  logic             clk_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [Q_W-1:0]   den_i,
  output logic [DIV_W-1:0] quo_o
);

  div_st_t        st_s  [DIV_PIPE];
  div_st_t        st_d  [DIV_PIPE];
  div_st_t        st_q  [DIV_PIPE];
  logic [Q_W-1:0] den_s [DIV_PIPE];
  logic [Q_W-1:0] den_q [DIV_PIPE];

  // Feed the first stage from the ports, the rest from the stage before
  assign st_s[0]  = {{Q_W{1'b0}}, num_i};
  assign den_s[0] = den_i;
  for (genvar k = 1; k < DIV_PIPE; k++) begin : g_link
    assign st_s[k]  = st_q[k-1];
    assign den_s[k] = den_q[k-1];
  end

  // Step in the leading stages, pass through the padding stages
  for (genvar k = 0; k < DIV_PIPE; k++) begin : g_stage
    if (k < DIV_STG) begin : g_work
      assign st_d[k] = div_step2(st_s[k], den_s[k]);
    end else begin : g_pass
      assign st_d[k] = st_s[k];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    den_q <= den_s;
  end

  assign quo_o = st_q[DIV_PIPE-1].quo;

endmodule

@@ rtl/core/v3au_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root: two root bits per stage
module v3au_sqrt_pipe import v3au_pkg::*; (
  input  logic             clk_i,
  input  logic [RAD_W-1:0] rad_i,
  output logic [Q_W-1:0]   root_o
);

  sq_st_t st_s [SQ_PIPE];
  sq_st_t st_d [SQ_PIPE];
  sq_st_t st_q [SQ_PIPE];

  // Chain the stages
  assign st_s[0] = {{SQ_REM_W{1'b0}}, {Q_W{1'b0}}, rad_i};
  for (genvar k = 1; k < SQ_PIPE; k++) begin : g_link
    assign st_s[k] = st_q[k-1];
  end

  // Step in the leading stages, pass through the padding stages
  for (genvar k = 0; k < SQ_PIPE; k++) begin : g_stage
    if (k < SQ_STG) begin : g_work
      assign st_d[k] = sq_step2(st_s[k]);
    end else begin : g_pass
      assign st_d[k] = st_s[k];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign root_o = st_q[SQ_PIPE-1].root;

endmodule

@@ rtl/core/v3au_front.sv @@
`timescale 1ns / 1ps
// Front stage: operand select, six multipliers, add/subtract and divider setup
module v3au_front import v3au_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  in_t                      item_i,
  output f_ctl_t                   ctl_o,
  output logic signed [PROD_W-1:0] prod_o [6],
  output logic signed [Q_W-1:0]    as_o   [3],
  output logic [DIV_W-1:0]         num_o  [3],
  output logic [Q_W-1:0]           den_o
);

  logic signed [Q_W-1:0]    a     [3];
  logic signed [Q_W-1:0]    b     [3];
  logic signed [Q_W-1:0]    ml    [6];
  logic signed [Q_W-1:0]    mr    [6];
  logic signed [PROD_W-1:0] prod_d [6];
  logic signed [QX_W-1:0]   as_w  [3];
  logic signed [Q_W-1:0]    as_d  [3];
  logic [Q_W-1:0]           absa  [3];
  logic [DIV_W-1:0]         num_d [3];
  logic [Q_W-1:0]           den_d;
  logic signed [Q_W-1:0]    s;
  f_ctl_t                   ctl_d;
  f_ctl_t                   ctl_q;
  logic                     is_cross;
  logic                     is_scale;
  logic                     is_mag;

  assign a[0] = item_i.a_x;
  assign a[1] = item_i.a_y;
  assign a[2] = item_i.a_z;
  assign b[0] = item_i.b_x;
  assign b[1] = item_i.b_y;
  assign b[2] = item_i.b_z;
  assign s    = item_i.scale_factor;

  assign is_cross = (item_i.op == OP_CROSS);
  assign is_scale = (item_i.op == OP_SCALE);
  assign is_mag   = (item_i.op == OP_MAG);

  // Route operands: lanes 0-2 serve scale, dot, squares and cross, 3-5 cross only
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ml[i] = a[i];
      if (is_scale) begin
        mr[i] = s;
      end else if (is_mag) begin
        mr[i] = a[i];
      end else begin
        mr[i] = b[i];
      end
    end
    if (is_cross) begin
      ml[0] = a[1];
      mr[0] = b[2];
      ml[1] = a[2];
      mr[1] = b[0];
      ml[2] = a[0];
      mr[2] = b[1];
    end
    ml[3] = a[2];
    mr[3] = b[1];
    ml[4] = a[0];
    mr[4] = b[2];
    ml[5] = a[1];
    mr[5] = b[0];
    for (int i = 0; i < 6; i++) begin
      prod_d[i] = PROD_W'(ml[i]) * PROD_W'(mr[i]);
    end
  end

  // Add or subtract with clamp, and set up the divider magnitudes
  always_comb begin
    ctl_d       = '0;
    ctl_d.valid = valid_i;
    ctl_d.op    = item_i.op;
    ctl_d.dz    = (item_i.op == OP_DIV) && (s == '0);
    for (int i = 0; i < 3; i++) begin
      if (item_i.op == OP_SUB) begin
        as_w[i] = QX_W'(a[i]) - QX_W'(b[i]);
      end else begin
        as_w[i] = QX_W'(a[i]) + QX_W'(b[i]);
      end
      ctl_d.as_ov[i] = as_w[i][Q_W] ^ as_w[i][Q_W-1];
      if (ctl_d.as_ov[i]) begin
        as_d[i] = as_w[i][Q_W] ? Q_MIN : Q_MAX;
      end else begin
        as_d[i] = as_w[i][Q_W-1:0];
      end
      ctl_d.neg[i] = a[i][Q_W-1] ^ s[Q_W-1];
      absa[i]      = a[i][Q_W-1] ? (~a[i] + 1'b1) : a[i];
      num_d[i]     = DIV_W'(absa[i]) << FRAC_BITS;
    end
    den_d = s[Q_W-1] ? (~s + 1'b1) : s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
    as_o   <= as_d;
    num_o  <= num_d;
    den_o  <= den_d;
  end

  assign ctl_o = ctl_q;

endmodule

@@ rtl/core/v3au_checker.sv @@
`timescale 1ns / 1ps
// Port checker for the vector arithmetic unit, bound to the top level
`include "assert_macros.svh"
module v3au_checker import v3au_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic done_o,
  input out_t result_o
);

  // A result beat only follows an accepted command beat
  `V3AU_ASSERT_MSG(a_done_after_start, clk_i, rst_ni, done_o |-> $past(start && !busy, LATENCY), "result beat without command beat")

  // Divide by zero gives a zero result and no overflow
  `V3AU_ASSERT(a_dz_zero_result, clk_i, rst_ni, (done_o && result_o.div_zero) |-> (!result_o.overflow && result_o.res_x == '0 && result_o.res_y == '0 && result_o.res_z == '0 && result_o.res_scalar == '0))

  // Divide by zero flag comes only from a divide with a zero scalar
  `V3AU_ASSERT(a_dz_cause, clk_i, rst_ni, (done_o && result_o.div_zero) |-> ($past(item_i.op, LATENCY) == OP_DIV && $past(item_i.scale_factor, LATENCY) == '0))

  // Vector operations leave the scalar field at zero
  `V3AU_ASSERT(a_vec_scalar_zero, clk_i, rst_ni, (done_o && ($past(item_i.op, LATENCY) == OP_ADD || $past(item_i.op, LATENCY) == OP_SUB || $past(item_i.op, LATENCY) == OP_SCALE || $past(item_i.op, LATENCY) == OP_DIV || $past(item_i.op, LATENCY) == OP_CROSS)) |-> result_o.res_scalar == '0)

endmodule

bind vector3_arith_unit v3au_checker u_v3au_checker (.*);

@@ dv/vector3_arith_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench: random and directed regression of the vector arithmetic unit
module vector3_arith_unit_tb;
  import v3au_pkg::*;

  localparam logic [2:0] OP_NONE   = 3'd7;
  localparam int         IDLE_LIM  = 4000;
  localparam int         N_RANDOM  = 1300;

  typedef logic signed [95:0] wide_t;

  // Expected-result store and vector math predictor
  class vec_scoreboard;
    out_t pending_q[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Clamp to the Q range and flag saturation
    function automatic logic signed [Q_W-1:0] clamp_q(input wide_t v, inout bit ov);
      if (v > wide_t'(Q_MAX)) begin
        ov = 1'b1;
        return Q_MAX;
      end
      if (v < wide_t'(Q_MIN)) begin
        ov = 1'b1;
        return Q_MIN;
      end
      return v[Q_W-1:0];
    endfunction

    // Round to nearest with ties up, drop the fraction
    function automatic wide_t round_q(input wide_t v);
      return (v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic [65:0] int_sqrt(input logic [65:0] v);
      logic [65:0] res;
      logic [65:0] bitv;
      res  = '0;
      bitv = 66'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic out_t vec_result(input in_t it);
      out_t  r;
      wide_t a[3];
      wide_t b[3];
      wide_t s;
      bit    ov;
      logic [65:0] sq;
      r  = '0;
      ov = 1'b0;
      a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
      b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
      s = it.scale_factor;
      case (it.op)
        OP_ADD: begin
          r.res_x = clamp_q(a[0] + b[0], ov);
          r.res_y = clamp_q(a[1] + b[1], ov);
          r.res_z = clamp_q(a[2] + b[2], ov);
        end
        OP_SUB: begin
          r.res_x = clamp_q(a[0] - b[0], ov);
          r.res_y = clamp_q(a[1] - b[1], ov);
          r.res_z = clamp_q(a[2] - b[2], ov);
        end
        OP_SCALE: begin
          r.res_x = clamp_q(round_q(a[0] * s), ov);
          r.res_y = clamp_q(round_q(a[1] * s), ov);
          r.res_z = clamp_q(round_q(a[2] * s), ov);
        end
        OP_DIV: begin
          if (s == 0) begin
            r.div_zero = 1'b1;
          end else begin
            r.res_x = clamp_q((a[0] <<< FRAC_BITS) / s, ov);
            r.res_y = clamp_q((a[1] <<< FRAC_BITS) / s, ov);
            r.res_z = clamp_q((a[2] <<< FRAC_BITS) / s, ov);
          end
        end
        OP_MAG: begin
          sq = 66'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
          r.res_scalar = clamp_q(wide_t'(int_sqrt(sq)), ov);
        end
        OP_DOT: begin
          r.res_scalar = clamp_q(round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), ov);
        end
        OP_CROSS: begin
          r.res_x = clamp_q(round_q(a[1] * b[2] - a[2] * b[1]), ov);
          r.res_y = clamp_q(round_q(a[2] * b[0] - a[0] * b[2]), ov);
          r.res_z = clamp_q(round_q(a[0] * b[1] - a[1] * b[0]), ov);
        end
        default: ;
      endcase
      r.overflow = ov;
      return r;
    endfunction

    function void note_command(input in_t it);
      pending_q.push_back(vec_result(it));
    endfunction

    task report(input string what, input logic [Q_W-1:0] got, input logic [Q_W-1:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(input out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        report("unexpected beat", got.res_x, '0);
        return;
      end
      want = pending_q.pop_front();
      if (got.res_x !== want.res_x) report("res_x", got.res_x, want.res_x);
      if (got.res_y !== want.res_y) report("res_y", got.res_y, want.res_y);
      if (got.res_z !== want.res_z) report("res_z", got.res_z, want.res_z);
      if (got.res_scalar !== want.res_scalar)
        report("res_scalar", got.res_scalar, want.res_scalar);
      if (got.div_zero !== want.div_zero) report("div_zero", got.div_zero, want.div_zero);
      if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic done_o;
  out_t result_o;

  vec_scoreboard sb;
  int            idle_cycles;
  bit            calm;

  vector3_arith_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Note accepted commands, check results, and watch for a stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_command(item_i);
      if (done_o) sb.check_result(result_o);
      if ((start && !busy) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIM) begin
        $display("vector3_arith_unit regression: fail");
        $finish;
      end
    end
  end

  // Hold a command until it is taken, after a random gap
  task send_cmd(input in_t it);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 70) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic signed [Q_W-1:0] rand_q();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return ($urandom_range(0, 1) != 0) ? 32'sh0001_0000 : -32'sh0001_0000;
      4: return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
      5: return $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t make_cmd(input logic [2:0] op, input logic signed [Q_W-1:0] a,
                                   input logic signed [Q_W-1:0] b,
                                   input logic signed [Q_W-1:0] s);
    in_t it;
    it.op = op;
    it.a_x = a; it.a_y = -a; it.a_z = a >>> 3;
    it.b_x = b; it.b_y = b >>> 5; it.b_z = -b;
    it.scale_factor = s;
    return it;
  endfunction

  initial begin
    in_t it;
    int  n;
    sb          = new();
    idle_cycles = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every operation, division by zero, opcode seven, tie rounding
    send_cmd(make_cmd(OP_ADD, Q_MAX, Q_MAX, 0));
    send_cmd(make_cmd(OP_ADD, Q_MIN, Q_MIN, 0));
    send_cmd(make_cmd(OP_SUB, Q_MIN, Q_MAX, 0));
    send_cmd(make_cmd(OP_SUB, 32'sh0001_8000, 32'sh0000_8000, 0));
    send_cmd(make_cmd(OP_SCALE, Q_MAX, 0, Q_MAX));
    send_cmd(make_cmd(OP_SCALE, Q_MIN, 0, Q_MIN));
    send_cmd(make_cmd(OP_SCALE, 32'sh0000_0001, 0, 32'sh0000_8000));
    send_cmd(make_cmd(OP_SCALE, -32'sh0000_0001, 0, 32'sh0000_8000));
    send_cmd(make_cmd(OP_DIV, 32'sh0003_0000, 0, '0));
    send_cmd(make_cmd(OP_DIV, Q_MIN, 0, -32'sh1));
    send_cmd(make_cmd(OP_DIV, Q_MAX, 0, 32'sh1));
    send_cmd(make_cmd(OP_DIV, -32'sh0007_0000, 0, 32'sh0002_0000));
    send_cmd(make_cmd(OP_MAG, Q_MIN, 0, 0));
    send_cmd(make_cmd(OP_MAG, 32'sh0003_0000, 0, 0));
    send_cmd(make_cmd(OP_MAG, '0, 0, 0));
    send_cmd(make_cmd(OP_DOT, Q_MAX, Q_MAX, 0));
    send_cmd(make_cmd(OP_DOT, Q_MIN, Q_MAX, 0));
    send_cmd(make_cmd(OP_DOT, 32'sh0000_0001, 32'sh0000_8000, 0));
    send_cmd(make_cmd(OP_CROSS, Q_MIN, Q_MAX, 0));
    send_cmd(make_cmd(OP_CROSS, 32'sh0001_0000, 32'sh0002_0000, 0));
    send_cmd(make_cmd(OP_NONE, Q_MAX, Q_MIN, Q_MAX));

    // Random commands in stretches with and without gaps
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      it.op = ($urandom_range(0, 19) == 0) ? OP_NONE : 3'($urandom_range(0, 6));
      it.a_x = rand_q(); it.a_y = rand_q(); it.a_z = rand_q();
      it.b_x = rand_q(); it.b_y = rand_q(); it.b_z = rand_q();
      it.scale_factor = ($urandom_range(0, 9) == 0) ? '0 : rand_q();
      send_cmd(it);
    end
    @(negedge clk_i);
    start <= 1'b0;

    // Drain, then allow quiet time beyond the pipeline depth
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("vector3_arith_unit regression: pass");
    end else begin
      $display("vector3_arith_unit regression: fail");
    end
    $finish;
  end

endmodule
